>>> hw/rtl/wcr_pkg.sv
// Package for the whitespace compactor: character codes, configuration
// register indexes and the job descriptor passed from front end to back end.
// No dependencies.
`default_nettype none

package wcr_pkg;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharSpace = 8'h20;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 1;
  localparam logic [CfgIdxW-1:0] CfgTrimTail = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgReflow   = 1'd1;

  // One descriptor expands into: nlf newlines, then an optional space,
  // then an optional visible byte; a descriptor with none of these is a
  // bare chunk-done marker.
  typedef struct packed {
    logic [1:0] nlf;
    logic       sp;
    logic       vis;
    logic [7:0] vis_byte;
    logic       done;
  } desc_t;

endpackage

`default_nettype wire

>>> hw/rtl/wcr_in_if.sv
// Input channel of the whitespace compactor: valid/ready plus one raw byte.
// No dependencies.
`default_nettype none

interface wcr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       chunk_end;

  modport source (output valid, output in_byte, output chunk_end, input ready);
  modport sink   (input valid, input in_byte, input chunk_end, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/wcr_out_if.sv
// Output channel of the whitespace compactor: valid/ready plus one result.
// No dependencies.
`default_nettype none

interface wcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       chunk_done;
  logic       last;

  modport source (output valid, output out_byte, output out_valid,
                  output chunk_done, output last, input ready);
  modport sink   (input valid, input out_byte, input out_valid,
                  input chunk_done, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/wcr_front.sv
// Front end: accepts raw bytes, tracks space and newline state and builds
// one descriptor per request that releases output. Uses wcr_pkg, wcr_in_if.
`default_nettype none

module wcr_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           trim_tail_i,
  input  wire logic           reflow_i,
  wcr_in_if.sink              in_i,
  output wcr_pkg::desc_t      desc_o,
  output logic                push_o,
  input  wire logic           full_i
);

  logic       last_was_space_q, last_was_space_d;
  logic [1:0] newline_run_q, newline_run_d;
  logic [1:0] pend_nl_q, pend_nl_d;
  logic       pend_sp_q, pend_sp_d;

  logic       accept;
  logic [7:0] ch;
  logic [2:0] nl_total;
  logic [1:0] nl_add;
  logic       resolve;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  always_comb begin
    last_was_space_d = last_was_space_q;
    newline_run_d    = newline_run_q;
    pend_nl_d        = pend_nl_q;
    pend_sp_d        = pend_sp_q;
    nl_add           = 2'd0;
    nl_total         = 3'd0;
    resolve          = 1'b0;
    desc_o           = '0;
    ch               = (in_i.in_byte == wcr_pkg::CharTab) ? wcr_pkg::CharSpace : in_i.in_byte;

    if (in_i.in_byte != wcr_pkg::CharCr) begin
      if (ch == wcr_pkg::CharLf) begin
        pend_sp_d = 1'b0;
        if (newline_run_q != 2'd3) begin
          newline_run_d = newline_run_q + 2'd1;
        end
        if (reflow_i) begin
          nl_add = (newline_run_d == 2'd2) ? 2'd2 : 2'd0;
        end else begin
          nl_add = (newline_run_d != 2'd3) ? 2'd1 : 2'd0;
        end
        nl_total  = {1'b0, pend_nl_q} + {1'b0, nl_add};
        pend_nl_d = (nl_total > 3'd2) ? 2'd2 : nl_total[1:0];
        last_was_space_d = 1'b0;
      end else begin
        resolve       = reflow_i && (newline_run_q == 2'd1);
        newline_run_d = 2'd0;
        if (ch == wcr_pkg::CharSpace) begin
          if (!last_was_space_q) begin
            pend_sp_d        = 1'b1;
            last_was_space_d = 1'b1;
          end
        end else begin
          // Release held newlines, then the held or reflowed space, then the byte
          desc_o.nlf      = pend_nl_q;
          desc_o.sp       = pend_sp_q || (resolve && !last_was_space_q);
          desc_o.vis      = 1'b1;
          desc_o.vis_byte = ch;
          pend_nl_d        = 2'd0;
          pend_sp_d        = 1'b0;
          last_was_space_d = 1'b0;
        end
      end
    end

    if (in_i.chunk_end) begin
      desc_o.done = 1'b1;
      if (!trim_tail_i && !desc_o.vis) begin
        desc_o.nlf = pend_nl_d;
        desc_o.sp  = pend_sp_d;
      end
      pend_nl_d = 2'd0;
      pend_sp_d = 1'b0;
    end

    push_o = accept && (desc_o.vis || desc_o.done);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_was_space_q <= 1'b0;
      newline_run_q    <= 2'd0;
      pend_nl_q        <= 2'd0;
      pend_sp_q        <= 1'b0;
    end else if (accept) begin
      last_was_space_q <= last_was_space_d;
      newline_run_q    <= newline_run_d;
      pend_nl_q        <= pend_nl_d;
      pend_sp_q        <= pend_sp_d;
    end
  end

  pend_nl_max_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_nl_q != 2'd3)
    else $error("held newline count above two");

  pend_cleared_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.chunk_end |=> pend_nl_q == 2'd0 && !pend_sp_q)
    else $error("held whitespace survived a chunk end");

  lf_drops_space_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.in_byte == wcr_pkg::CharLf |=> !pend_sp_q)
    else $error("space held across a newline");

endmodule

`default_nettype wire

>>> hw/rtl/wcr_fifo.sv
// Short descriptor queue between front and back end, register based.
// Uses wcr_pkg.
`default_nettype none

module wcr_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire wcr_pkg::desc_t wdata_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output wcr_pkg::desc_t      rdata_o,
  output logic                nonempty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  wcr_pkg::desc_t  mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntFull);
  assign nonempty_o = (cnt_q != '0);
  assign rdata_o    = mem_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrMax) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrMax) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  cnt_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("queue count beyond depth");

  full_ptrs_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> wptr_q == rptr_q)
    else $error("full queue with pointers apart");

  ptr_track_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> wptr_q == rptr_q)
    else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

>>> hw/rtl/wcr_back.sv
// Back end: expands one descriptor into output bytes, one per cycle unless
// stalled, into a registered output stage. Uses wcr_pkg, wcr_out_if.
`default_nettype none

module wcr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire wcr_pkg::desc_t desc_i,
  input  wire logic           desc_valid_i,
  output logic                pop_o,
  wcr_out_if.source           out_o
);

  wcr_pkg::desc_t work_q, work_d;
  logic           work_v_q, work_v_d;

  logic       ov_q;
  logic [7:0] obyte_q;
  logic       obval_q, odone_q, olast_q;

  wcr_pkg::desc_t rem;
  logic [7:0]     res_byte;
  logic           res_bval, res_last, out_load;

  always_comb begin
    rem      = work_q;
    res_byte = 8'd0;
    res_bval = 1'b1;
    priority if (work_q.nlf != 2'd0) begin
      res_byte = wcr_pkg::CharLf;
      rem.nlf  = work_q.nlf - 2'd1;
    end else if (work_q.sp) begin
      res_byte = wcr_pkg::CharSpace;
      rem.sp   = 1'b0;
    end else if (work_q.vis) begin
      res_byte = work_q.vis_byte;
      rem.vis  = 1'b0;
    end else begin
      // Bare chunk-done marker
      res_bval = 1'b0;
    end
    res_last = (rem.nlf == 2'd0) && !rem.sp && !rem.vis;

    out_load = work_v_q && (!ov_q || out_o.ready);
    pop_o    = desc_valid_i && (!work_v_q || (out_load && res_last));

    work_d   = work_q;
    work_v_d = work_v_q;
    if (out_load) begin
      work_d   = rem;
      work_v_d = !res_last;
    end
    if (pop_o) begin
      work_d   = desc_i;
      work_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (out_load) begin
      obyte_q <= res_byte;
      obval_q <= res_bval;
      odone_q <= res_last && work_q.done;
      olast_q <= res_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      work_v_q <= work_v_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.out_byte   = obyte_q;
  assign out_o.out_valid  = obval_q;
  assign out_o.chunk_done = odone_q;
  assign out_o.last       = olast_q;

  marker_only_alone_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !res_bval |-> res_last && work_q.done)
    else $error("marker emitted from a descriptor with bytes or no chunk end");

  no_pop_mid_job_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_v_q && !(out_load && res_last) |-> !pop_o)
    else $error("descriptor taken while another is still expanding");

  stall_holds_work_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_o.ready && work_v_q |=> work_v_q)
    else $error("work dropped during output stall");

endmodule

`default_nettype wire

>>> hw/rtl/whitespace_compactor_reflow.sv
// Top level of the whitespace compactor: configuration registers, front end,
// descriptor queue and back end. Uses wcr_pkg, wcr_in_if, wcr_out_if,
// wcr_front, wcr_fifo, wcr_back.
//
// Usage:
//   in_i carries one raw text byte per request (in_byte) plus chunk_end on
//   the last byte of a chunk. out_o carries one result per request: a byte
//   with out_valid 1, or a bare marker (out_valid 0, out_byte 0) when a
//   chunk end releases nothing. last marks the final result of an input
//   request, chunk_done the final result of a chunk_end request.
//   The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) writes
//   trim_tail (index 0) and reflow_single_newlines (index 1); write only
//   while the block is idle.
// Timing:
//   The front end takes one input request per cycle while the queue has
//   room. The back end emits one result per cycle while the receiver is
//   ready; a request releases up to four results, and the back end takes
//   no new descriptor until the last of them is loaded. The first result
//   of an input passes through the queue, then the expansion register,
//   then the output register on its way to out_o.
// Reset and stall:
//   Reset clears all whitespace state and the queue, and sets both
//   configuration bits to 1. When the receiver stalls, the output register
//   holds, the back end stops, the queue fills and in_i.ready drops.
`default_nettype none

module whitespace_compactor_reflow #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [wcr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [wcr_pkg::CfgDataW-1:0] cfg_data_i,
  wcr_in_if.sink                            in_i,
  wcr_out_if.source                         out_o
);

  // Configuration registers
  logic trim_tail_q;
  logic reflow_q;

  // Front to queue
  wcr_pkg::desc_t front_desc;
  logic           front_push;
  logic           queue_full;

  // Queue to back
  wcr_pkg::desc_t queue_desc;
  logic           queue_nonempty;
  logic           back_pop;

  // Take register writes; unknown indexes are ignored by the case default
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_tail_q <= 1'b1;
      reflow_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wcr_pkg::CfgTrimTail: trim_tail_q <= cfg_data_i[0];
        wcr_pkg::CfgReflow:   reflow_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Classify input bytes and track held whitespace
  wcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .trim_tail_i (trim_tail_q),
    .reflow_i    (reflow_q),
    .in_i        (in_i),
    .desc_o      (front_desc),
    .push_o      (front_push),
    .full_i      (queue_full)
  );

  // Decouple the front, one request per cycle, from the back, one byte per cycle; either may stall
  wcr_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (front_push),
    .wdata_i    (front_desc),
    .full_o     (queue_full),
    .pop_i      (back_pop),
    .rdata_o    (queue_desc),
    .nonempty_o (queue_nonempty)
  );

  // Expand descriptors into output bytes
  wcr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (queue_desc),
    .desc_valid_i (queue_nonempty),
    .pop_o        (back_pop),
    .out_o        (out_o)
  );

  marker_flags_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.out_valid |-> out_o.chunk_done && out_o.last &&
    out_o.out_byte == 8'd0)
    else $error("bare marker without chunk_done and last");

  done_is_last_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.chunk_done |-> out_o.last)
    else $error("chunk_done on a result that is not the last");

  ready_tracks_queue_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == !queue_full)
    else $error("input ready disagrees with queue space");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for whitespace_compactor_reflow.
// Uses wcr_pkg, wcr_in_if and wcr_out_if from the RTL; the DUT's output stream
// is checked against an in-bench model of the compaction rules.
`default_nettype none

module tb_top;
  import wcr_pkg::*;

  // One input request as the sender sees it.
  typedef struct packed {
    logic [7:0] b;
    logic       e;
  } raw_req_t;

  // One output request, field for field as on out_o.
  typedef struct packed {
    logic [7:0] ob;
    logic       ov;
    logic       cd;
    logic       lst;
  } result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  wcr_in_if  in_if ();
  wcr_out_if out_if ();

  whitespace_compactor_reflow u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #4 clk_i = ~clk_i;

  // Requests still to be sent, and bytes the DUT still owes us.
  raw_req_t raw_q[$];
  result_t  compacted_q[$];

  // Handshake bookkeeping shared between the driver, the monitor and the ready
  // driver. Each counter has exactly one writer.
  int unsigned in_taken_cnt  = 0;
  int unsigned in_offer_cnt  = 0;
  int unsigned out_taken_cnt = 0;
  int unsigned out_seen_cnt  = 0;
  int unsigned in_wait       = 0;
  int unsigned out_wait      = 0;
  logic        in_idle_on    = 1'b0;
  logic        out_idle_on   = 1'b0;

  // Long receiver hold-off: requested from the sequence, counted here.
  logic        rx_hold_req   = 1'b0;
  int unsigned rx_hold_left  = 0;

  // Run statistics and error count.
  int unsigned n_errors  = 0;
  int unsigned n_chunks  = 0;
  int unsigned n_markers = 0;
  int unsigned n_stalls  = 0;

  // Model state: the four whitespace trackers and the two config bits.
  logic       m_last_sp;
  logic [1:0] m_nl_run;
  logic [1:0] m_pend_nl;
  logic       m_pend_sp;
  logic       m_trim;
  logic       m_reflow;
  logic [7:0] released[$];

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 40) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic int unsigned draw_wait(input logic on);
    if (!on || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // Release held newlines, then a held space, into the byte list.
  task automatic release_held();
    for (int k = 0; k < m_pend_nl; k++) released.push_back(CharLf);
    if (m_pend_sp) released.push_back(CharSpace);
    m_pend_nl = 2'd0;
    m_pend_sp = 1'b0;
  endtask

  // Advance the model by one accepted byte and queue the results it causes.
  task automatic compact_byte(input logic [7:0] raw, input logic is_end);
    logic [7:0] c;
    logic [1:0] add;
    logic [2:0] total;
    logic       resolve;
    logic       had_sp;
    result_t    r;
    c = raw;
    released.delete();
    if (c != CharCr) begin
      if (c == CharTab) c = CharSpace;
      if (c == CharLf) begin
        // A newline kills any held space; the run count saturates at three.
        m_pend_sp = 1'b0;
        if (m_nl_run != 2'd3) m_nl_run = m_nl_run + 2'd1;
        add = 2'd0;
        if (m_reflow) begin
          if (m_nl_run == 2'd2) add = 2'd2;
        end else if (m_nl_run <= 2'd2) begin
          add = 2'd1;
        end
        total = {1'b0, m_pend_nl} + {1'b0, add};
        m_pend_nl = (total > 3'd2) ? 2'd2 : total[1:0];
        m_last_sp = 1'b0;
      end else begin
        // A lone newline in reflow mode turns into a space before the next
        // visible byte, unless a space is already there.
        resolve = m_reflow && (m_nl_run == 2'd1);
        m_nl_run = 2'd0;
        if (c == CharSpace) begin
          if (!m_last_sp) begin
            m_pend_sp = 1'b1;
            m_last_sp = 1'b1;
          end
        end else begin
          had_sp = m_pend_sp;
          release_held();
          if (resolve && !m_last_sp && !had_sp) released.push_back(CharSpace);
          released.push_back(c);
          m_last_sp = 1'b0;
        end
      end
    end
    // Chunk end: drop or flush the tail, leaving the run trackers alone.
    if (is_end) begin
      if (m_trim) begin
        m_pend_nl = 2'd0;
        m_pend_sp = 1'b0;
      end else begin
        release_held();
      end
    end
    if (released.size() == 0) begin
      if (is_end) begin
        r = '{ob: 8'd0, ov: 1'b0, cd: 1'b1, lst: 1'b1};
        compacted_q.push_back(r);
      end
    end else begin
      foreach (released[k]) begin
        r.ob  = released[k];
        r.ov  = 1'b1;
        r.lst = (k == released.size() - 1);
        r.cd  = r.lst && is_end;
        compacted_q.push_back(r);
      end
    end
  endtask

  // Driver: change inputs on the falling edge. Once the current request has
  // gone through, wait the drawn gap, then offer the next one. Valid gets a
  // single assignment per edge so back-to-back requests never glitch.
  always @(negedge clk_i) begin
    logic     offer;
    raw_req_t nxt;
    offer = in_if.valid;
    if (offer && in_taken_cnt == in_offer_cnt) begin
      offer = 1'b0;
      in_wait = draw_wait(in_idle_on);
    end
    if (!offer && rst_ni) begin
      if (in_wait != 0) begin
        in_wait--;
      end else if (raw_q.size() != 0) begin
        nxt = raw_q.pop_front();
        in_if.in_byte   <= nxt.b;
        in_if.chunk_end <= nxt.e;
        offer = 1'b1;
        in_offer_cnt++;
      end
    end
    in_if.valid <= offer;
  end

  // Receiver: after each result, hold ready low for the drawn number of
  // cycles; the long hold-off overrides everything while it runs.
  always @(negedge clk_i) begin
    if (out_taken_cnt != out_seen_cnt) begin
      out_seen_cnt = out_taken_cnt;
      out_wait = draw_wait(out_idle_on);
    end
    if (out_wait != 0) begin
      out_wait--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rst_ni && (rx_hold_left == 0);
    end
  end

  // Count the long hold-off down in its own process.
  always @(posedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_left = 120;
      rx_hold_req  = 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left--;
    end
  end

  // Monitor: sample both channels on the rising edge. Predict first, so a
  // request and its results can never be seen in the wrong order.
  always @(posedge clk_i) begin
    raw_req_t got_in;
    result_t  want;
    if (rst_ni) begin
      if (in_if.valid && !in_if.ready) n_stalls++;
      if (in_if.valid && in_if.ready) begin
        in_taken_cnt++;
        got_in = '{b: in_if.in_byte, e: in_if.chunk_end};
        if (got_in.e) n_chunks++;
        compact_byte(got_in.b, got_in.e);
      end
      if (out_if.valid && out_if.ready) begin
        out_taken_cnt++;
        if (compacted_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h", out_if.out_byte));
        end else begin
          want = compacted_q.pop_front();
          if (!want.ov) n_markers++;
          if (out_if.out_byte !== want.ob)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_if.out_byte, want.ob));
          if (out_if.out_valid !== want.ov)
            report_mismatch($sformatf("out_valid %b, want %b", out_if.out_valid, want.ov));
          if (out_if.chunk_done !== want.cd)
            report_mismatch($sformatf("chunk_done %b, want %b", out_if.chunk_done, want.cd));
          if (out_if.last !== want.lst)
            report_mismatch($sformatf("last %b, want %b", out_if.last, want.lst));
        end
      end
    end
  end

  task automatic push_req(input logic [7:0] b, input logic e);
    raw_q.push_back('{b: b, e: e});
  endtask

  // Hold until every request is sent and every result is back, then let the
  // pipeline settle (requests that release nothing may still be in flight).
  task automatic wait_drained();
    while (raw_q.size() != 0 || in_if.valid || compacted_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CfgTrimTail) m_trim = val;
    else m_reflow = val;
  endtask

  task automatic set_mode(input logic trim, input logic reflow);
    write_cfg(CfgTrimTail, trim);
    write_cfg(CfgReflow, reflow);
  endtask

  // Random text: mostly words, blank runs and newline runs, with some raw
  // noise bytes mixed in. Carriage returns without a chunk end do nothing,
  // so they are not counted.
  task automatic add_random_text(input int unsigned n_items);
    int unsigned added;
    int unsigned kind;
    int unsigned len;
    logic [7:0]  b;
    logic        e;
    added = 0;
    while (added < n_items) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
        case (kind)
          0, 1, 2, 3: b = 8'($urandom_range(8'h21, 8'h7E));
          4, 5:       b = $urandom_range(0, 1) ? CharSpace : CharTab;
          6: begin
            case ($urandom_range(0, 3))
              0, 1:    b = CharLf;
              2:       b = CharSpace;
              default: b = CharCr;
            endcase
          end
          7:       b = CharLf;
          default: b = 8'($urandom_range(0, 255));
        endcase
        e = ($urandom_range(0, 11) == 0);
        push_req(b, e);
        if (b != CharCr || e) added++;
      end
    end
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.in_byte   = 8'd0;
    in_if.chunk_end = 1'b0;
    out_if.ready    = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CfgTrimTail;
    cfg_data_i      = 1'b0;
    m_last_sp       = 1'b0;
    m_nl_run        = 2'd0;
    m_pend_nl       = 2'd0;
    m_pend_sp       = 1'b0;
    m_trim          = 1'b1;
    m_reflow        = 1'b1;
    rst_ni          = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset settings (trim and reflow on): byte extremes, a lone
    // newline resolved to a space, blank runs with a tab, a paragraph break,
    // a carriage return closing a chunk, trimmed tails giving bare markers.
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    push_req(8'h00, 1'b0);
    push_req("a", 1'b0);
    push_req(CharLf, 1'b0);
    push_req("b", 1'b0);
    push_req(CharSpace, 1'b0);
    push_req(CharTab, 1'b0);
    push_req(CharLf, 1'b0);
    push_req(CharSpace, 1'b0);
    push_req(CharLf, 1'b0);
    push_req(CharLf, 1'b0);
    push_req("c", 1'b0);
    push_req(CharCr, 1'b1);
    push_req(CharSpace, 1'b1);
    push_req(8'hFF, 1'b0);
    push_req(CharLf, 1'b1);
    wait_drained();

    // Directed, both bits off: a flushed newline tail, newline runs split by
    // blanks saturating at two held newlines, a four-byte release, a flushed
    // space, and a carriage return that produces nothing at all.
    set_mode(1'b0, 1'b0);
    push_req(CharLf, 1'b0);
    push_req(CharLf, 1'b0);
    push_req(CharLf, 1'b1);
    push_req(CharLf, 1'b0);
    push_req(CharSpace, 1'b0);
    push_req(CharLf, 1'b0);
    push_req(CharSpace, 1'b0);
    push_req(CharLf, 1'b0);
    push_req(CharSpace, 1'b0);
    push_req("x", 1'b1);
    push_req(CharSpace, 1'b1);
    push_req(CharCr, 1'b0);
    wait_drained();

    // Random phases across all four settings, then a random one. The first
    // phase runs the sender flat out against a long receiver hold-off so the
    // queue fills and in_i.ready drops.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       set_mode(1'b1, 1'b1);
        1:       set_mode(1'b0, 1'b0);
        2:       set_mode(1'b1, 1'b0);
        3:       set_mode(1'b0, 1'b1);
        default: set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      in_idle_on  = (p == 1 || p == 3 || p == 4);
      out_idle_on = (p == 1 || p == 2 || p == 4);
      if (p == 0) begin
        @(negedge clk_i);
        rx_hold_req = 1'b1;
      end
      add_random_text(100);
      wait_drained();
    end

    $display("Covered %0d input requests, %0d results, %0d chunk ends, %0d bare markers.",
             in_taken_cnt, out_taken_cnt, n_chunks, n_markers);
    $display("Sender saw %0d stalled cycles; all four register settings were exercised.",
             n_stalls);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
